@@ sv/hrj_pkg.sv @@
// ----------------------------------------------------------------------------
// hrj_pkg
// Shared types and constants for the homography residual / Jacobian pipeline.
// ----------------------------------------------------------------------------
package hrj_pkg;

  typedef struct packed {
    logic signed [31:0] plane_x;
    logic signed [31:0] plane_y;
    logic signed [31:0] image_x;
    logic signed [31:0] image_y;
  } hrj_in_t;

  typedef struct packed {
    logic signed [63:0] res_u;
    logic signed [63:0] res_v;
    logic signed [63:0] x_over_w;
    logic signed [63:0] y_over_w;
    logic signed [63:0] inv_w;
    logic signed [63:0] du_dh20;
    logic signed [63:0] du_dh21;
    logic signed [63:0] dv_dh20;
    logic signed [63:0] dv_dh21;
    logic               degenerate;
  } hrj_out_t;

  typedef enum logic [7:0] {
    REG_H00 = 8'd0,
    REG_H01 = 8'd1,
    REG_H02 = 8'd2,
    REG_H10 = 8'd3,
    REG_H11 = 8'd4,
    REG_H12 = 8'd5,
    REG_H20 = 8'd6,
    REG_H21 = 8'd7
  } hrj_reg_t;

  localparam int MUL_LAT = 3;
  localparam int DIV_LAT = 67;
  localparam int WW      = 98;   // W, NU, NV
  localparam int WNA     = 160;  // numerators over W
  localparam int WNB     = 212;  // numerators over W^2

  localparam logic signed [63:0] H_ONE = 64'sd1099511627776;

endpackage

@@ sv/hrj_dly.sv @@
// ----------------------------------------------------------------------------
// hrj_dly
// Fixed-length delay line for payload that rides alongside the pipeline.
// ----------------------------------------------------------------------------
module hrj_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[N-1];

endmodule

@@ sv/hrj_mul.sv @@
// ----------------------------------------------------------------------------
// hrj_mul
// Signed multiplier built from 33x33 partial products over three stages:
// partials, row sums, final sum.
// ----------------------------------------------------------------------------
module hrj_mul #(
  parameter int WA = 64,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int WF = 32 * (NA + NB);

  logic signed [32*NA-1:0] ax;
  logic signed [32*NB-1:0] bx;
  logic signed [32:0]      ac [NA];
  logic signed [32:0]      bc [NB];
  logic signed [65:0]      pp_r [NA][NB];
  logic signed [WF-1:0]    row_nxt [NA];
  logic signed [WF-1:0]    row_r [NA];
  logic signed [WF-1:0]    sum_nxt;
  logic signed [WF-1:0]    sum_r;

  assign ax = (32*NA)'(a);
  assign bx = (32*NB)'(b);

  for (genvar i = 0; i < NA; i++) begin : g_ac
    if (i == NA - 1) begin : g_top
      assign ac[i] = {ax[32*i+31], ax[32*i +: 32]};
    end else begin : g_low
      assign ac[i] = {1'b0, ax[32*i +: 32]};
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bc
    if (j == NB - 1) begin : g_top
      assign bc[j] = {bx[32*j+31], bx[32*j +: 32]};
    end else begin : g_low
      assign bc[j] = {1'b0, bx[32*j +: 32]};
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (WF'(pp_r[i][j]) <<< (32*j));
      end
    end
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (row_r[i] <<< (32*i));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= ac[i] * bc[j];
      end
      row_r[i] <= row_nxt[i];
    end
    sum_r <= sum_nxt;
  end

  assign p = sum_r[WA+WB-1:0];

endmodule

@@ sv/hrj_div.sv @@
// ----------------------------------------------------------------------------
// hrj_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and saturating the quotient to 64 bits signed.
// ----------------------------------------------------------------------------
module hrj_div #(
  parameter int WN = 160
) (
  input  logic                 clk,
  input  logic signed [WN-1:0] num,
  input  logic signed [WN-1:0] den,
  output logic signed [63:0]   q
);

  logic [WN-1:0] an_r, ad_r;
  logic          sg_r;
  logic [WN-1:0] an0, ad0;

  logic [WN-1:0] rem_r [65];
  logic [63:0]   lo_r  [65];
  logic [WN-1:0] dv_r  [65];
  logic [63:0]   qt_r  [65];
  logic          sgn_r [65];
  logic          ovf_r [65];
  logic          ovf;

  logic signed [63:0] q_r;

  assign an0 = num[WN-1] ? (~num + 1'b1) : num;
  assign ad0 = den[WN-1] ? (~den + 1'b1) : den;
  assign ovf = {64'b0, an_r} >= {ad_r, 64'b0};

  always_ff @(posedge clk) begin
    an_r <= an0;
    ad_r <= ad0;
    sg_r <= num[WN-1] ^ den[WN-1];

    rem_r[0] <= WN'(an_r[WN-1:64]);
    lo_r[0]  <= an_r[63:0];
    dv_r[0]  <= ad_r;
    qt_r[0]  <= '0;
    sgn_r[0] <= sg_r;
    ovf_r[0] <= ovf;
  end

  for (genvar k = 0; k < 64; k++) begin : g_stage
    logic [WN:0] t;
    logic        ge;
    assign t  = {rem_r[k], lo_r[k][63]};
    assign ge = t >= {1'b0, dv_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? WN'(t - {1'b0, dv_r[k]}) : t[WN-1:0];
      lo_r[k+1]  <= {lo_r[k][62:0], 1'b0};
      dv_r[k+1]  <= dv_r[k];
      qt_r[k+1]  <= {qt_r[k][62:0], ge};
      sgn_r[k+1] <= sgn_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf_r[64] || qt_r[64][63]) begin
      q_r <= sgn_r[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      q_r <= sgn_r[64] ? -$signed(qt_r[64]) : $signed(qt_r[64]);
    end
  end

  assign q = q_r;

endmodule

@@ sv/homography_residual_jacobian.sv @@
// ----------------------------------------------------------------------------
// homography_residual_jacobian
// Homography reprojection residuals and Jacobian entries, one point per beat.
// ----------------------------------------------------------------------------
// A correspondence is taken on every clock where start is high; busy is
// always low. Each result appears on out_data with out_valid high for one
// cycle, in the order of the start beats; the latency is set by the
// 64-stage bit-per-stage dividers plus the two three-stage multiplier banks.
// Results cannot be held off, so the sink must take every beat.
// Homography registers are written through the cfg port, by the user only while
// no points are in flight (the block does not enforce it); cfg_ready is always high.
// ----------------------------------------------------------------------------
module homography_residual_jacobian
  import hrj_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  hrj_in_t     in_data,
  output logic        out_valid,
  output hrj_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int PIPE = 2*MUL_LAT + 3 + DIV_LAT;
  localparam logic signed [WW-1:0] W_BIAS = WW'(1) <<< 56;
  localparam logic signed [WNA-1:0] N_INV = WNA'(1) <<< 96;

  logic signed [63:0] h00_r, h01_r, h02_r, h10_r, h11_r, h12_r, h20_r, h21_r;
  logic [PIPE-1:0]    vld_r;
  hrj_in_t            in_r, pts_a, pts_b;
  logic               out_valid_r;
  hrj_out_t           out_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h00_r <= H_ONE; h01_r <= '0; h02_r <= '0;
      h10_r <= '0;    h11_r <= H_ONE; h12_r <= '0;
      h20_r <= '0;    h21_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_H00: h00_r <= cfg_data;
        REG_H01: h01_r <= cfg_data;
        REG_H02: h02_r <= cfg_data;
        REG_H10: h10_r <= cfg_data;
        REG_H11: h11_r <= cfg_data;
        REG_H12: h12_r <= cfg_data;
        REG_H20: h20_r <= cfg_data;
        REG_H21: h21_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[PIPE-2:0], start & ~busy};
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // first product bank
  logic signed [95:0] p20x, p21y, p00x, p01y, p10x, p11y;

  hrj_mul #(.WA(64), .WB(32)) u_m20 (.clk, .a(h20_r), .b(in_r.plane_x), .p(p20x));
  hrj_mul #(.WA(64), .WB(32)) u_m21 (.clk, .a(h21_r), .b(in_r.plane_y), .p(p21y));
  hrj_mul #(.WA(64), .WB(32)) u_m00 (.clk, .a(h00_r), .b(in_r.plane_x), .p(p00x));
  hrj_mul #(.WA(64), .WB(32)) u_m01 (.clk, .a(h01_r), .b(in_r.plane_y), .p(p01y));
  hrj_mul #(.WA(64), .WB(32)) u_m10 (.clk, .a(h10_r), .b(in_r.plane_x), .p(p10x));
  hrj_mul #(.WA(64), .WB(32)) u_m11 (.clk, .a(h11_r), .b(in_r.plane_y), .p(p11y));

  hrj_dly #(.W($bits(hrj_in_t)), .N(MUL_LAT + 1)) u_dly_pa (
    .clk, .d(in_r), .q(pts_a)
  );

  logic signed [WW-1:0] w_r, nu_r, nv_r;

  always_ff @(posedge clk) begin
    w_r  <= WW'(p20x) + WW'(p21y) + W_BIAS;
    nu_r <= WW'(p00x) + WW'(p01y) + (WW'(h02_r) <<< 16);
    nv_r <= WW'(p10x) + WW'(p11y) + (WW'(h12_r) <<< 16);
  end

  // second product bank
  logic signed [2*WW-1:0] ww_p;
  logic signed [WW+31:0]  ixw, iyw, nux, nuy, nvx, nvy;

  hrj_mul #(.WA(WW), .WB(WW)) u_mww (.clk, .a(w_r), .b(w_r), .p(ww_p));
  hrj_mul #(.WA(WW), .WB(32)) u_mix (.clk, .a(w_r),  .b(pts_a.image_x), .p(ixw));
  hrj_mul #(.WA(WW), .WB(32)) u_miy (.clk, .a(w_r),  .b(pts_a.image_y), .p(iyw));
  hrj_mul #(.WA(WW), .WB(32)) u_mux (.clk, .a(nu_r), .b(pts_a.plane_x), .p(nux));
  hrj_mul #(.WA(WW), .WB(32)) u_muy (.clk, .a(nu_r), .b(pts_a.plane_y), .p(nuy));
  hrj_mul #(.WA(WW), .WB(32)) u_mvx (.clk, .a(nv_r), .b(pts_a.plane_x), .p(nvx));
  hrj_mul #(.WA(WW), .WB(32)) u_mvy (.clk, .a(nv_r), .b(pts_a.plane_y), .p(nvy));

  hrj_dly #(.W($bits(hrj_in_t)), .N(MUL_LAT)) u_dly_pb (
    .clk, .d(pts_a), .q(pts_b)
  );

  logic signed [3*WW-1:0] wn_d;
  logic signed [WW-1:0]   w_d, nu_d, nv_d;

  hrj_dly #(.W(3*WW), .N(MUL_LAT)) u_dly_w (
    .clk, .d({w_r, nu_r, nv_r}), .q(wn_d)
  );

  assign w_d  = wn_d[3*WW-1:2*WW];
  assign nu_d = wn_d[2*WW-1:WW];
  assign nv_d = wn_d[WW-1:0];

  // numerators and denominators
  logic signed [WNA-1:0] nru_r, nrv_r, nx_r, ny_r, da_r;
  logic signed [WNB-1:0] c0_r, c1_r, c2_r, c3_r, db_r;
  logic                  deg_r, deg_d;

  always_ff @(posedge clk) begin
    nru_r <= (WNA'(nu_d) <<< 40) - (WNA'(ixw) <<< 24);
    nrv_r <= (WNA'(nv_d) <<< 40) - (WNA'(iyw) <<< 24);
    nx_r  <= WNA'(pts_b.plane_x) <<< 80;
    ny_r  <= WNA'(pts_b.plane_y) <<< 80;
    da_r  <= WNA'(w_d);
    c0_r  <= -(WNB'(nux) <<< 80);
    c1_r  <= -(WNB'(nuy) <<< 80);
    c2_r  <= -(WNB'(nvx) <<< 80);
    c3_r  <= -(WNB'(nvy) <<< 80);
    db_r  <= WNB'(ww_p);
    deg_r <= (w_d == '0);
  end

  hrj_dly #(.W(1), .N(DIV_LAT)) u_dly_deg (.clk, .d(deg_r), .q(deg_d));

  logic signed [63:0] q_ru, q_rv, q_x, q_y, q_i, q_c0, q_c1, q_c2, q_c3;

  hrj_div #(.WN(WNA)) u_d_ru (.clk, .num(nru_r), .den(da_r), .q(q_ru));
  hrj_div #(.WN(WNA)) u_d_rv (.clk, .num(nrv_r), .den(da_r), .q(q_rv));
  hrj_div #(.WN(WNA)) u_d_x  (.clk, .num(nx_r),  .den(da_r), .q(q_x));
  hrj_div #(.WN(WNA)) u_d_y  (.clk, .num(ny_r),  .den(da_r), .q(q_y));
  hrj_div #(.WN(WNA)) u_d_i  (.clk, .num(N_INV), .den(da_r), .q(q_i));
  hrj_div #(.WN(WNB)) u_d_c0 (.clk, .num(c0_r),  .den(db_r), .q(q_c0));
  hrj_div #(.WN(WNB)) u_d_c1 (.clk, .num(c1_r),  .den(db_r), .q(q_c1));
  hrj_div #(.WN(WNB)) u_d_c2 (.clk, .num(c2_r),  .den(db_r), .q(q_c2));
  hrj_div #(.WN(WNB)) u_d_c3 (.clk, .num(c3_r),  .den(db_r), .q(q_c3));

  always_ff @(posedge clk) begin
    if (deg_d) begin
      out_r.res_u      <= '0;
      out_r.res_v      <= '0;
      out_r.x_over_w   <= '0;
      out_r.y_over_w   <= '0;
      out_r.inv_w      <= '0;
      out_r.du_dh20    <= '0;
      out_r.du_dh21    <= '0;
      out_r.dv_dh20    <= '0;
      out_r.dv_dh21    <= '0;
      out_r.degenerate <= 1'b1;
    end else begin
      out_r.res_u      <= q_ru;
      out_r.res_v      <= q_rv;
      out_r.x_over_w   <= q_x;
      out_r.y_over_w   <= q_y;
      out_r.inv_w      <= q_i;
      out_r.du_dh20    <= q_c0;
      out_r.du_dh21    <= q_c1;
      out_r.dv_dh20    <= q_c2;
      out_r.dv_dh21    <= q_c3;
      out_r.degenerate <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
